@@ design/isp_pkg.sv @@
// Shared types and constants of the instruction stream prefetcher.
package isp_pkg;

  localparam int unsigned TRAIN_ENTRIES    = 16;
  localparam int unsigned MONITOR_ENTRIES  = 16;
  localparam int unsigned LINE_OFFSET_BITS = 6;
  localparam int unsigned ADDRESS_BITS     = 48;

  localparam int unsigned LINE_BITS     = ADDRESS_BITS - LINE_OFFSET_BITS;
  localparam int unsigned TR_IDX_BITS   = $clog2(TRAIN_ENTRIES);
  localparam int unsigned MON_IDX_BITS  = $clog2(MONITOR_ENTRIES);
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 3;

  // Distance and degree values above this act as this.
  localparam logic [2:0] PF_CAP = 3'd4;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WINDOW    = 2'd1,
    CFG_DISTANCE  = 2'd2,
    CFG_DEGREE    = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    SRC_MONITOR = 1'b0,
    SRC_INITIAL = 1'b1
  } pf_src_e;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] access_address;
    logic                    ic_hit;
    logic                    pf_line_hit;
  } in_item_t;

  typedef struct packed {
    logic [ADDRESS_BITS-1:0] prefetch_address;
    logic                    prefetch_source;
    logic                    last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [LINE_BITS-1:0] mon_line;
    logic [2:0]           mon_left;
    logic [LINE_BITS-1:0] init_line;
    logic [1:0]           init_left;
  } run_t;

endpackage

@@ design/isp_emit.sv @@
// Run sequencer that turns one run of prefetch lines into output items.
module isp_emit import isp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      run_load_i,
  input  run_t      run_i,
  output logic      run_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  run_t      run_q, run_d;
  out_item_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      slot;
  logic      step;
  logic [2:0] remaining;

  assign remaining = run_q.mon_left + {1'b0, run_q.init_left};

  always_comb begin
    slot        = !out_valid_q || out_ready_i;
    step        = slot && (remaining != 3'd0);
    run_ready_o = (remaining == 3'd0) || ((remaining == 3'd1) && slot);
    run_d       = run_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (step) begin
      out_valid_d       = 1'b1;
      out_d.last_of_run = (remaining == 3'd1);
      if (run_q.mon_left != 3'd0) begin
        out_d.prefetch_address = {run_q.mon_line, {LINE_OFFSET_BITS{1'b0}}};
        out_d.prefetch_source  = SRC_MONITOR;
        run_d.mon_line         = run_q.mon_line + LINE_BITS'(1);
        run_d.mon_left         = run_q.mon_left - 3'd1;
      end else begin
        out_d.prefetch_address = {run_q.init_line, {LINE_OFFSET_BITS{1'b0}}};
        out_d.prefetch_source  = SRC_INITIAL;
        run_d.init_line        = run_q.init_line + LINE_BITS'(1);
        run_d.init_left        = run_q.init_left - 2'd1;
      end
    end
    if (run_load_i) begin
      run_d = run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ design/instr_stream_prefetcher.sv @@
// Top level of the instruction stream prefetcher: training and monitoring tables.
// An item is registered on acceptance and updates both tables when it advances,
// once the output sequencer can take its run. Its prefetches leave one per cycle
// from the output register while the output is ready; the output sequencer sets
// the rate. Items without prefetches go at one per cycle while it is idle.
// Reset clears all valid bits and sets the ages and config registers to defaults.
module instr_stream_prefetcher import isp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_item_t                 in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_item_t                out_item_o
);

  localparam logic [TR_IDX_BITS-1:0]  TR_AGE_LAST  = TR_IDX_BITS'(TRAIN_ENTRIES - 1);
  localparam logic [MON_IDX_BITS-1:0] MON_AGE_LAST = MON_IDX_BITS'(MONITOR_ENTRIES - 1);

  logic [1:0] thr_q;
  logic [2:0] win_q, dist_q, deg_q;

  in_item_t in_q;
  logic     in_valid_q;
  logic     in_advance;
  logic     run_ready;
  run_t     run;

  logic [TRAIN_ENTRIES-1:0] tr_valid_q, tr_valid_d;
  logic [LINE_BITS-1:0]     tr_start_q [TRAIN_ENTRIES];
  logic [LINE_BITS-1:0]     tr_start_d [TRAIN_ENTRIES];
  logic [1:0]               tr_hits_q  [TRAIN_ENTRIES];
  logic [1:0]               tr_hits_d  [TRAIN_ENTRIES];
  logic [TR_IDX_BITS-1:0]   tr_age_q   [TRAIN_ENTRIES];
  logic [TR_IDX_BITS-1:0]   tr_age_d   [TRAIN_ENTRIES];

  logic [MONITOR_ENTRIES-1:0] mon_valid_q, mon_valid_d;
  logic [LINE_BITS-1:0]       mon_start_q [MONITOR_ENTRIES];
  logic [LINE_BITS-1:0]       mon_start_d [MONITOR_ENTRIES];
  logic [MON_IDX_BITS-1:0]    mon_age_q   [MONITOR_ENTRIES];
  logic [MON_IDX_BITS-1:0]    mon_age_d   [MONITOR_ENTRIES];
  logic [MON_IDX_BITS-1:0]    mon_age_a   [MONITOR_ENTRIES];

  logic [LINE_BITS-1:0]    line;
  logic                    vmiss;
  logic [2:0]              dist_eff, deg_eff;
  logic                    mon_hit, tr_hit, promote;
  logic [MON_IDX_BITS-1:0] mon_idx, mon_vict, mon_cur, mon_cur2;
  logic [TR_IDX_BITS-1:0]  tr_idx, tr_vict, tr_touch_idx, tr_cur;
  logic                    tr_touch;
  logic [1:0]              hits_new;

  always_comb begin
    line     = in_q.access_address[ADDRESS_BITS-1:LINE_OFFSET_BITS];
    vmiss    = !in_q.ic_hit || in_q.pf_line_hit;
    dist_eff = (dist_q > PF_CAP) ? PF_CAP : dist_q;
    deg_eff  = (deg_q > PF_CAP) ? PF_CAP : deg_q;

    // The lowest matching index wins in both tables.
    mon_hit = 1'b0;
    mon_idx = '0;
    for (int k = MONITOR_ENTRIES - 1; k >= 0; k--) begin
      if (mon_valid_q[k] && (mon_start_q[k] <= line) &&
          ((line - mon_start_q[k]) < {{(LINE_BITS-3){1'b0}}, dist_eff})) begin
        mon_hit = 1'b1;
        mon_idx = MON_IDX_BITS'(k);
      end
    end

    tr_hit = 1'b0;
    tr_idx = '0;
    for (int k = TRAIN_ENTRIES - 1; k >= 0; k--) begin
      if (vmiss && tr_valid_q[k] && (tr_start_q[k] <= line) &&
          ((line - tr_start_q[k]) < {{(LINE_BITS-3){1'b0}}, win_q})) begin
        tr_hit = 1'b1;
        tr_idx = TR_IDX_BITS'(k);
      end
    end

    hits_new = (tr_hits_q[tr_idx] == 2'd3) ? 2'd3 : tr_hits_q[tr_idx] + 2'd1;
    promote  = tr_hit && (hits_new >= thr_q);

    // Monitor table: touch on a hit, then a promotion takes the LRU slot.
    mon_valid_d = mon_valid_q;
    mon_start_d = mon_start_q;
    mon_age_a   = mon_age_q;
    mon_cur     = mon_age_q[mon_idx];
    if (mon_hit) begin
      for (int k = 0; k < MONITOR_ENTRIES; k++) begin
        if (mon_age_q[k] < mon_cur) begin
          mon_age_a[k] = mon_age_q[k] + MON_IDX_BITS'(1);
        end
      end
      mon_age_a[mon_idx]   = '0;
      mon_start_d[mon_idx] = mon_start_q[mon_idx] + {{(LINE_BITS-3){1'b0}}, deg_eff};
    end
    mon_vict = '0;
    for (int k = 0; k < MONITOR_ENTRIES; k++) begin
      if (mon_age_a[k] == MON_AGE_LAST) begin
        mon_vict = MON_IDX_BITS'(k);
      end
    end
    mon_age_d = mon_age_a;
    mon_cur2  = mon_age_a[mon_vict];
    if (promote) begin
      for (int k = 0; k < MONITOR_ENTRIES; k++) begin
        if (mon_age_a[k] < mon_cur2) begin
          mon_age_d[k] = mon_age_a[k] + MON_IDX_BITS'(1);
        end
      end
      mon_age_d[mon_vict]   = '0;
      mon_valid_d[mon_vict] = 1'b1;
      mon_start_d[mon_vict] = line;
    end

    // Training table: count a hit, promote, or allocate the LRU slot.
    tr_valid_d = tr_valid_q;
    tr_start_d = tr_start_q;
    tr_hits_d  = tr_hits_q;
    tr_vict    = '0;
    for (int k = 0; k < TRAIN_ENTRIES; k++) begin
      if (tr_age_q[k] == TR_AGE_LAST) begin
        tr_vict = TR_IDX_BITS'(k);
      end
    end
    tr_touch     = 1'b0;
    tr_touch_idx = tr_idx;
    if (tr_hit) begin
      if (promote) begin
        tr_valid_d[tr_idx] = 1'b0;
      end else begin
        tr_hits_d[tr_idx] = hits_new;
        tr_touch          = 1'b1;
      end
    end else if (vmiss && !mon_hit) begin
      tr_valid_d[tr_vict] = 1'b1;
      tr_start_d[tr_vict] = line;
      tr_hits_d[tr_vict]  = 2'd0;
      tr_touch            = 1'b1;
      tr_touch_idx        = tr_vict;
    end
    tr_age_d = tr_age_q;
    tr_cur   = tr_age_q[tr_touch_idx];
    if (tr_touch) begin
      for (int k = 0; k < TRAIN_ENTRIES; k++) begin
        if (tr_age_q[k] < tr_cur) begin
          tr_age_d[k] = tr_age_q[k] + TR_IDX_BITS'(1);
        end
      end
      tr_age_d[tr_touch_idx] = '0;
    end

    run.mon_line  = mon_start_q[mon_idx] + {{(LINE_BITS-3){1'b0}}, dist_eff};
    run.mon_left  = mon_hit ? deg_eff : 3'd0;
    run.init_line = line + LINE_BITS'(1);
    run.init_left = (promote && (dist_eff != 3'd0)) ? 2'(dist_eff - 3'd1) : 2'd0;
  end

  assign in_advance = in_valid_q && run_ready;
  assign in_ready_o = !in_valid_q || in_advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q       <= 2'd3;
      win_q       <= 3'd2;
      dist_q      <= 3'd2;
      deg_q       <= 3'd2;
      in_valid_q  <= 1'b0;
      tr_valid_q  <= '0;
      mon_valid_q <= '0;
      for (int k = 0; k < TRAIN_ENTRIES; k++) begin
        tr_age_q[k] <= TR_IDX_BITS'(k);
      end
      for (int k = 0; k < MONITOR_ENTRIES; k++) begin
        mon_age_q[k] <= MON_IDX_BITS'(k);
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_THRESHOLD: thr_q  <= cfg_wdata_i[1:0];
          CFG_WINDOW:    win_q  <= cfg_wdata_i;
          CFG_DISTANCE:  dist_q <= cfg_wdata_i;
          CFG_DEGREE:    deg_q  <= cfg_wdata_i;
          default:       ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (in_advance) begin
        in_valid_q <= 1'b0;
      end
      if (in_advance) begin
        tr_valid_q  <= tr_valid_d;
        mon_valid_q <= mon_valid_d;
        tr_age_q    <= tr_age_d;
        mon_age_q   <= mon_age_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (in_advance) begin
      tr_start_q  <= tr_start_d;
      tr_hits_q   <= tr_hits_d;
      mon_start_q <= mon_start_d;
    end
  end

  isp_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_load_i  (in_advance),
    .run_i       (run),
    .run_ready_o (run_ready),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ bench/isp_checker.sv @@
// Checker of the instruction stream prefetcher: predicts each item's prefetches and compares.
module isp_checker import isp_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  in_item_t                 in_item_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  out_item_t                out_item_i,
  output int unsigned              fail_count_o,
  output int unsigned              pend_count_o
);

  logic [1:0] cfg_threshold;
  logic [2:0] cfg_window;
  logic [2:0] cfg_distance;
  logic [2:0] cfg_degree;

  logic [TRAIN_ENTRIES-1:0]                     tr_valid;
  logic [TRAIN_ENTRIES-1:0][LINE_BITS-1:0]      tr_start;
  logic [TRAIN_ENTRIES-1:0][1:0]                tr_hits;
  logic [TRAIN_ENTRIES-1:0][TR_IDX_BITS-1:0]    tr_age;
  logic [MONITOR_ENTRIES-1:0]                   mon_valid;
  logic [MONITOR_ENTRIES-1:0][LINE_BITS-1:0]    mon_start;
  logic [MONITOR_ENTRIES-1:0][MON_IDX_BITS-1:0] mon_age;

  out_item_t   pending_prefetches[$];
  out_item_t   run_buf[8];
  int unsigned mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic logic in_window(input logic [LINE_BITS-1:0] ln, start,
                                     input logic [2:0] size);
    return (start <= ln) && ((ln - start) < size);
  endfunction

  function automatic out_item_t prefetch_of(input logic [LINE_BITS-1:0] ln,
                                            input pf_src_e src);
    out_item_t r;
    r.prefetch_address = {ln, {LINE_OFFSET_BITS{1'b0}}};
    r.prefetch_source  = src;
    r.last_of_run      = 1'b0;
    return r;
  endfunction

  task automatic touch_train(input int pos);
    logic [TR_IDX_BITS-1:0] cur;
    cur = tr_age[pos];
    for (int k = 0; k < TRAIN_ENTRIES; k++) begin
      if (tr_age[k] < cur) tr_age[k] = tr_age[k] + 1'b1;
    end
    tr_age[pos] = '0;
  endtask

  task automatic touch_monitor(input int pos);
    logic [MON_IDX_BITS-1:0] cur;
    cur = mon_age[pos];
    for (int k = 0; k < MONITOR_ENTRIES; k++) begin
      if (mon_age[k] < cur) mon_age[k] = mon_age[k] + 1'b1;
    end
    mon_age[pos] = '0;
  endtask

  task automatic predict_prefetches(input in_item_t it);
    logic [LINE_BITS-1:0] ln;
    logic [2:0]           pf_dist;
    logic [2:0]           deg;
    logic                 vmiss;
    logic                 mon_hit;
    logic                 tr_hit;
    int                   n;
    int                   v;
    ln      = it.access_address[ADDRESS_BITS-1:LINE_OFFSET_BITS];
    pf_dist = (cfg_distance > PF_CAP) ? PF_CAP : cfg_distance;
    deg     = (cfg_degree > PF_CAP) ? PF_CAP : cfg_degree;
    vmiss   = !it.ic_hit || it.pf_line_hit;
    mon_hit = 1'b0;
    tr_hit  = 1'b0;
    n       = 0;

    for (int i = 0; i < MONITOR_ENTRIES && !mon_hit; i++) begin
      if (mon_valid[i] && in_window(ln, mon_start[i], pf_dist)) begin
        for (int j = 0; j < deg; j++) begin
          run_buf[n] = prefetch_of(mon_start[i] + pf_dist, SRC_MONITOR);
          n = n + 1;
          mon_start[i] = mon_start[i] + 1'b1;
        end
        touch_monitor(i);
        mon_hit = 1'b1;
      end
    end

    if (vmiss) begin
      for (int i = 0; i < TRAIN_ENTRIES && !tr_hit; i++) begin
        if (tr_valid[i] && in_window(ln, tr_start[i], cfg_window)) begin
          if (tr_hits[i] != 2'd3) tr_hits[i] = tr_hits[i] + 1'b1;
          if (tr_hits[i] >= cfg_threshold) begin
            for (int j = 1; j < pf_dist; j++) begin
              run_buf[n] = prefetch_of(ln + j, SRC_INITIAL);
              n = n + 1;
            end
            v = 0;
            for (int k = 1; k < MONITOR_ENTRIES; k++) begin
              if (mon_age[k] > mon_age[v]) v = k;
            end
            mon_valid[v] = 1'b1;
            mon_start[v] = ln;
            touch_monitor(v);
            tr_valid[i] = 1'b0;
          end else begin
            touch_train(i);
          end
          tr_hit = 1'b1;
        end
      end
      if (!mon_hit && !tr_hit) begin
        v = 0;
        for (int k = 1; k < TRAIN_ENTRIES; k++) begin
          if (tr_age[k] > tr_age[v]) v = k;
        end
        tr_valid[v] = 1'b1;
        tr_start[v] = ln;
        tr_hits[v]  = 2'd0;
        touch_train(v);
      end
    end

    for (int k = 0; k < n; k++) begin
      run_buf[k].last_of_run = (k == n - 1);
      pending_prefetches.insert(pending_prefetches.size(), run_buf[k]);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t exp;
    if (!rst_ni) begin
      cfg_threshold = 2'd3;
      cfg_window    = 3'd2;
      cfg_distance  = 3'd2;
      cfg_degree    = 3'd2;
      tr_valid      = '0;
      mon_valid     = '0;
      for (int k = 0; k < TRAIN_ENTRIES; k++) tr_age[k] = TR_IDX_BITS'(k);
      for (int k = 0; k < MONITOR_ENTRIES; k++) mon_age[k] = MON_IDX_BITS'(k);
      pending_prefetches.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (pending_prefetches.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected prefetch: addr %h src %0d last %0d",
                     out_item_i.prefetch_address, out_item_i.prefetch_source,
                     out_item_i.last_of_run);
          end
        end else begin
          exp = pending_prefetches.pop_front();
          if (out_item_i.prefetch_address !== exp.prefetch_address ||
              out_item_i.prefetch_source !== exp.prefetch_source ||
              out_item_i.last_of_run !== exp.last_of_run) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display({"Mismatch: expected addr %h src %0d last %0d, ",
                        "got addr %h src %0d last %0d"},
                       exp.prefetch_address, exp.prefetch_source, exp.last_of_run,
                       out_item_i.prefetch_address, out_item_i.prefetch_source,
                       out_item_i.last_of_run);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_prefetches(in_item_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_THRESHOLD: cfg_threshold = cfg_wdata_i[1:0];
          CFG_WINDOW:    cfg_window    = cfg_wdata_i;
          CFG_DISTANCE:  cfg_distance  = cfg_wdata_i;
          CFG_DEGREE:    cfg_degree    = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    pend_count_o = pending_prefetches.size();
  end

endmodule

@@ bench/testbench.sv @@
// Top of the prefetcher testbench: clock, reset, stimulus, idling and the verdict.
module testbench;
  import isp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned SETTLE_TICKS = 6;
  localparam int unsigned PHASES       = 9;
  localparam int unsigned PHASE_ITEMS  = 42;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     cfg_we      = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index   = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata   = '0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  in_item_t                 in_item     = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  out_item_t                out_item;
  int unsigned              fail_count;
  int unsigned              pend_count;
  logic                     idle_en     = 1'b1;
  int unsigned              cycle_count = 0;

  logic [LINE_BITS-1:0] stream_line[4];
  int unsigned          stream_left[4] = '{0, 0, 0, 0};

  instr_stream_prefetcher i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  isp_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .fail_count_o (fail_count),
    .pend_count_o (pend_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_item(input in_item_t it);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_item  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic fetch(input logic [LINE_BITS-1:0] ln, input logic hit, input logic pfh);
    in_item_t                    it;
    logic [LINE_OFFSET_BITS-1:0] off;
    off = LINE_OFFSET_BITS'($urandom);
    it.access_address = {ln, off};
    it.ic_hit         = hit;
    it.pf_line_hit    = pfh;
    send_item(it);
  endtask

  task automatic send_address(input logic [ADDRESS_BITS-1:0] addr, input logic hit,
                              input logic pfh);
    in_item_t it;
    it.access_address = addr;
    it.ic_hit         = hit;
    it.pf_line_hit    = pfh;
    send_item(it);
  endtask

  // Holds the input back until every predicted prefetch has left the block.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pend_count != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic apply_config(input logic [2:0] th, win, pf_dist, deg);
    logic [2:0] vals[4];
    vals = '{th, win, pf_dist, deg};
    for (int k = 0; k < 4; k++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_BITS'(k);
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  // Mostly interleaved streams that train and then run on, with some random noise.
  task automatic run_random(input int unsigned count);
    int unsigned                 done;
    int unsigned                 s;
    int unsigned                 step;
    logic                        counted;
    in_item_t                    it;
    logic [LINE_OFFSET_BITS-1:0] off;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 2) begin
        it.access_address = ADDRESS_BITS'({$urandom, $urandom});
        it.ic_hit         = 1'($urandom_range(0, 1));
        it.pf_line_hit    = 1'($urandom_range(0, 1));
        counted           = !it.ic_hit || it.pf_line_hit;
      end else begin
        s = $urandom_range(0, 3);
        if (stream_left[s] == 0) begin
          if ($urandom_range(0, 7) == 0) begin
            stream_line[s] = {LINE_BITS{1'b1}} - LINE_BITS'($urandom_range(0, 6));
          end else begin
            stream_line[s] = LINE_BITS'({$urandom, $urandom});
          end
          stream_left[s] = $urandom_range(6, 24);
        end
        off               = LINE_OFFSET_BITS'($urandom);
        it.access_address = {stream_line[s], off};
        it.ic_hit         = ($urandom_range(0, 2) == 0);
        it.pf_line_hit    = ($urandom_range(0, 3) == 0);
        counted           = 1'b1;
        stream_left[s]    = stream_left[s] - 1;
        step = $urandom_range(0, 5);
        if (step == 5) begin
          stream_line[s] = stream_line[s] + 2'd2;
        end else if (step >= 2) begin
          stream_line[s] = stream_line[s] + 1'b1;
        end
      end
      send_item(it);
      if (counted) done++;
    end
  endtask

  initial begin
    forever begin
      if (idle_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [LINE_BITS-1:0] base;
    logic [2:0]           th, win, pf_dist, deg;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Training up to promotion, then monitored runs, with the register defaults.
    base = 42'h2AB_CDEF_0123;
    fetch(base, 1'b0, 1'b0);
    fetch(base, 1'b0, 1'b0);
    fetch(base + 1'b1, 1'b1, 1'b1);
    fetch(base + 1'b1, 1'b0, 1'b0);
    fetch(base + 1'b1, 1'b1, 1'b0);
    fetch(base + 3'd4, 1'b1, 1'b1);
    fetch(base + 4'd9, 1'b1, 1'b0);
    // A stream on the top line wraps its prefetches round to line zero.
    send_address({ADDRESS_BITS{1'b1}}, 1'b0, 1'b0);
    send_address({ADDRESS_BITS{1'b1}}, 1'b0, 1'b0);
    send_address({ADDRESS_BITS{1'b1}}, 1'b0, 1'b1);
    send_address({ADDRESS_BITS{1'b1}}, 1'b0, 1'b0);
    send_address({ADDRESS_BITS{1'b1}}, 1'b1, 1'b0);
    send_address('0, 1'b0, 1'b0);
    send_address('0, 1'b1, 1'b1);
    settle();

    // Zero threshold promotes on the first hit, distance above the cap, zero degree.
    apply_config(3'd0, 3'd1, 3'd7, 3'd0);
    base = 42'h155_5555_5555;
    fetch(base, 1'b0, 1'b0);
    fetch(base, 1'b0, 1'b1);
    fetch(base + 2'd2, 1'b1, 1'b0);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin th = 3'd1; win = 3'd1; pf_dist = 3'd1; deg = 3'd1; end
        1: begin th = 3'd3; win = 3'd4; pf_dist = 3'd4; deg = 3'd4; end
        2: begin th = 3'd6; win = 3'd3; pf_dist = 3'd4; deg = 3'd1; end
        3: begin th = 3'd0; win = 3'd0; pf_dist = 3'd0; deg = 3'd0; end
        4: begin th = 3'd2; win = 3'd7; pf_dist = 3'd7; deg = 3'd7; end
        5: begin th = 3'd1; win = 3'd2; pf_dist = 3'd0; deg = 3'd3; end
        8: begin th = 3'd3; win = 3'd2; pf_dist = 3'd2; deg = 3'd2; end
        default: begin
          th      = 3'($urandom_range(0, 7));
          win     = 3'($urandom_range(0, 7));
          pf_dist = 3'($urandom_range(0, 7));
          deg     = 3'($urandom_range(0, 7));
        end
      endcase
      idle_en = (p != 2) && (p != PHASES - 1);
      apply_config(th, win, pf_dist, deg);
      run_random(PHASE_ITEMS);
      settle();
    end

    if (fail_count == 0 && pend_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/isp_pkg.sv
design/isp_emit.sv
design/instr_stream_prefetcher.sv
bench/isp_checker.sv
bench/testbench.sv
